>>> rtl/core/length_prefixed_message_deframer_unit_macros.svh
// Assertion macros for the length-prefixed message deframer.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LPMD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LPMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lpmd_pkg.sv
// Shared types and constants of the length-prefixed message deframer.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package lpmd_pkg;

    // Width of the payload length as carried by the variable-length integer.
    localparam int LEN_W       = 62;
    // Width in bits of the largest length the downstream side can count.
    localparam int LENGTH_BITS = 62;
    localparam int DATA_W      = 8;

    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [DATA_W-1:0] t_byte;
    typedef logic [1:0]        t_kind;
    typedef logic [2:0]        t_err;
    typedef logic [3:0]        t_hdr_cnt;
    typedef logic [1:0]        t_cfg_idx;
    typedef logic [LEN_W-1:0]  t_cfg_data;

    localparam t_len LEN_MAX = {LEN_W{1'b1}} >> (LEN_W - LENGTH_BITS);

    localparam t_hdr_cnt FIXED_HDR = 4'd2;
    localparam t_hdr_cnt MIN_HDR   = 4'd3;

    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_EMPTY   = 2'd1;
    localparam t_kind KIND_ERROR   = 2'd2;
    localparam t_kind KIND_DONE    = 2'd3;

    localparam t_err ERR_NONE    = 3'd0;
    localparam t_err ERR_VERSION = 3'd1;
    localparam t_err ERR_LIMIT   = 3'd2;
    localparam t_err ERR_PROTO   = 3'd3;
    localparam t_err ERR_STATE   = 3'd4;

    localparam t_cfg_idx CFG_MAX_LEN   = 2'd0;
    localparam t_cfg_idx CFG_VERSION   = 2'd1;
    localparam t_cfg_idx CFG_TEXT_MASK = 2'd2;

    localparam t_len  RST_MAX_LEN   = t_len'(65536);
    localparam t_byte RST_VERSION   = 8'h00;
    localparam t_byte RST_TEXT_MASK = 8'h01;

    typedef struct packed {
        t_kind kind;
        t_byte payload_byte;
        logic  is_text;
        logic  last_of_message;
        t_err  error_code;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/lpmd_in_if.sv
// Input channel of the deframer: one received byte or a stream end.
// Depends on lpmd_pkg.
`default_nettype none

interface lpmd_in_if;
    import lpmd_pkg::*;

    logic  valid;
    logic  ready;
    logic  func;
    t_byte data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lpmd_out_if.sv
// Result channel of the deframer: payload bytes, markers and errors.
// Depends on lpmd_pkg.
`default_nettype none

interface lpmd_out_if;
    import lpmd_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_byte payload_byte;
    logic  is_text;
    logic  last_of_message;
    t_err  error_code;

    modport source (output valid, output kind, output payload_byte, output is_text,
                    output last_of_message, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte, input is_text,
                    input last_of_message, input error_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/length_prefixed_message_deframer_unit.sv
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg, lpmd_in_if, lpmd_out_if and the assertion macro header.
//
//   channel   direction  transaction carries
//   --------  ---------  -----------------------------------------------------
//   i_msg     in         func (byte or stream end), data_byte
//   o_res     out        kind, payload_byte, is_text, last_of_message, error_code
//   i_cfg_*   in         register index and write data, no handshake
//
// One transaction is accepted per cycle unless the result side stalls. Each item
// passes the input register, then the parser step that updates the framing state
// and loads the result register. The parser step is one 62-bit shift, compare and
// decrement. Synchronous active-low reset restores the register defaults and the
// framing state; there is no clearing pass. When the result side stalls, the input
// register still takes one more transaction before i_msg.ready drops.
`default_nettype none

`include "length_prefixed_message_deframer_unit_macros.svh"

module length_prefixed_message_deframer_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire lpmd_pkg::t_cfg_idx   i_cfg_idx,
    input  wire lpmd_pkg::t_cfg_data  i_cfg_data,
    lpmd_in_if.sink                   i_msg,
    lpmd_out_if.source                o_res
);
    import lpmd_pkg::*;

    // Configuration registers.
    t_len     r_max_len;
    t_byte    r_version;
    t_byte    r_text_mask;

    // Input register stage.
    logic     r_in_valid;
    logic     r_in_func;
    t_byte    r_in_byte;

    // Framing state and its next values.
    t_hdr_cnt r_hdr_cnt,  n_hdr_cnt;
    t_hdr_cnt r_hdr_need, n_hdr_need;
    t_len     r_acc,      n_acc;
    t_len     r_remain,   n_remain;
    logic     r_in_payload, n_in_payload;
    logic     r_text,     n_text;
    t_err     r_sticky,   n_sticky;
    logic     r_done,     n_done;

    // Result register.
    logic     r_out_valid;
    t_result  r_res;

    logic     w_go;
    logic     w_has_res;
    t_result  w_res;
    logic     w_fail;
    t_err     w_fail_code;
    t_hdr_cnt w_hc_inc;
    t_len     w_acc_shift;
    t_hdr_cnt w_need_hdr;

    // The parser step fires when an item waits in the input register and the
    // result register is free or being emptied in this cycle.
    assign w_go        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_msg.ready = !r_in_valid || w_go;

    assign w_acc_shift = {r_acc[LEN_W-DATA_W-1:0], r_in_byte};
    // The two top bits of the first length byte select a 1, 2, 4 or 8 byte length.
    assign w_need_hdr  = FIXED_HDR + (t_hdr_cnt'(1) << r_in_byte[7:6]);
    assign w_hc_inc    = r_hdr_cnt + t_hdr_cnt'(1);

    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_hdr_need   = r_hdr_need;
        n_acc        = r_acc;
        n_remain     = r_remain;
        n_in_payload = r_in_payload;
        n_text       = r_text;
        n_sticky     = r_sticky;
        n_done       = r_done;
        w_has_res    = 1'b0;
        w_fail       = 1'b0;
        w_fail_code  = ERR_NONE;
        w_res        = '{kind: KIND_PAYLOAD, payload_byte: '0, is_text: 1'b0,
                         last_of_message: 1'b0, error_code: ERR_NONE};

        if (r_sticky != ERR_NONE) begin
            // A sticky error answers every item and freezes the state.
            w_has_res      = 1'b1;
            w_res.kind     = KIND_ERROR;
            w_res.error_code = r_sticky;
        end else if (r_done) begin
            // Anything after a clean stream end is a state error, not sticky.
            w_has_res      = 1'b1;
            w_res.kind     = KIND_ERROR;
            w_res.error_code = ERR_STATE;
        end else if (r_in_func) begin
            if (r_hdr_cnt != '0 || r_in_payload) begin
                w_fail      = 1'b1;
                w_fail_code = ERR_PROTO;
            end else begin
                n_done     = 1'b1;
                w_has_res  = 1'b1;
                w_res.kind = KIND_DONE;
            end
        end else if (r_in_payload) begin
            w_has_res             = 1'b1;
            w_res.kind            = KIND_PAYLOAD;
            w_res.payload_byte    = r_in_byte;
            w_res.is_text         = r_text;
            w_res.last_of_message = (r_remain <= t_len'(1));
            if (r_remain <= t_len'(1)) begin
                n_in_payload = 1'b0;
                n_remain     = '0;
                n_text       = 1'b0;
            end else begin
                n_remain = r_remain - t_len'(1);
            end
        end else begin
            unique case (r_hdr_cnt)
                4'd0: begin
                    if (r_in_byte != r_version) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_VERSION;
                    end
                end
                4'd1:      n_text = (r_in_byte & r_text_mask) != '0;
                FIXED_HDR: begin
                    n_hdr_need = w_need_hdr;
                    n_acc      = t_len'(r_in_byte[5:0]);
                end
                default:   n_acc = w_acc_shift;
            endcase

            if (!w_fail) begin
                n_hdr_cnt = w_hc_inc;
                if (w_hc_inc >= n_hdr_need) begin
                    // Header complete: check the length, then open the payload or report an empty message.
                    if (n_acc > r_max_len || n_acc > LEN_MAX) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_LIMIT;
                    end else if (n_acc == '0) begin
                        w_has_res             = 1'b1;
                        w_res.kind            = KIND_EMPTY;
                        w_res.is_text         = n_text;
                        w_res.last_of_message = 1'b1;
                        n_hdr_cnt             = '0;
                        n_hdr_need            = MIN_HDR;
                        n_text                = 1'b0;
                    end else begin
                        n_remain     = n_acc;
                        n_in_payload = 1'b1;
                        n_hdr_cnt    = '0;
                        n_hdr_need   = MIN_HDR;
                        n_acc        = '0;
                    end
                end
            end
        end

        if (w_fail) begin
            // Any failure drops the half-received message and latches the code.
            n_hdr_cnt        = '0;
            n_hdr_need       = MIN_HDR;
            n_acc            = '0;
            n_remain         = '0;
            n_in_payload     = 1'b0;
            n_text           = 1'b0;
            n_sticky         = w_fail_code;
            w_has_res        = 1'b1;
            w_res            = '{kind: KIND_ERROR, payload_byte: '0, is_text: 1'b0,
                                 last_of_message: 1'b0, error_code: w_fail_code};
        end
    end

    // Configuration writes must arrive only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= RST_MAX_LEN;
            r_version   <= RST_VERSION;
            r_text_mask <= RST_TEXT_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LEN:   r_max_len   <= i_cfg_data;
                CFG_VERSION:   r_version   <= i_cfg_data[DATA_W-1:0];
                CFG_TEXT_MASK: r_text_mask <= i_cfg_data[DATA_W-1:0];
                default:       ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_msg.ready) begin
            r_in_valid <= i_msg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_msg.valid && i_msg.ready) begin
            r_in_func <= i_msg.func;
            r_in_byte <= i_msg.data_byte;
        end
    end

    // Framing state advances once per parsed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt    <= '0;
            r_hdr_need   <= MIN_HDR;
            r_acc        <= '0;
            r_remain     <= '0;
            r_in_payload <= 1'b0;
            r_text       <= 1'b0;
            r_sticky     <= ERR_NONE;
            r_done       <= 1'b0;
        end else if (w_go) begin
            r_hdr_cnt    <= n_hdr_cnt;
            r_hdr_need   <= n_hdr_need;
            r_acc        <= n_acc;
            r_remain     <= n_remain;
            r_in_payload <= n_in_payload;
            r_text       <= n_text;
            r_sticky     <= n_sticky;
            r_done       <= n_done;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= w_has_res;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_has_res) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.kind            = r_res.kind;
    assign o_res.payload_byte    = r_res.payload_byte;
    assign o_res.is_text         = r_res.is_text;
    assign o_res.last_of_message = r_res.last_of_message;
    assign o_res.error_code      = r_res.error_code;

    // Header bytes and payload bytes are never outstanding at the same time.
    `LPMD_ASSERT_IMPL(a_hdr_or_payload, r_in_payload, r_hdr_cnt == '0, "header count set in payload")
    // The header count always stays below the number of header bytes needed.
    `LPMD_ASSERT_IMPL(a_hdr_bound, 1'b1, r_hdr_cnt < r_hdr_need, "header count overran need")
    // Once latched, an error code never changes until reset.
    `LPMD_ASSERT_NEXT(a_sticky_hold, r_sticky != ERR_NONE, r_sticky == $past(r_sticky), "sticky error changed")
    // An error result always carries a nonzero code.
    `LPMD_ASSERT_IMPL(a_err_code, r_out_valid && r_res.kind == KIND_ERROR, r_res.error_code != ERR_NONE, "error result without code")

endmodule

`default_nettype wire
